>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL that checks itself.
// Uses the clk and rst_n names of the module that includes this file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on clk, off during reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent this cycle, consequent in the next.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/ssc_pkg.sv
// Types, constants and decode functions of the servo segment clock sequencer.
// No dependencies.
package ssc_pkg;

  localparam int unsigned NumDigits   = 4;
  localparam int unsigned NumChannels = 14;
  localparam int unsigned NormalSlots = 24;
  localparam int unsigned PosFieldW   = 12;
  localparam int unsigned OffsetW     = 12;
  localparam int unsigned RawW        = 13;

  localparam logic [OffsetW-1:0] MID_OFFSET_RST = 12'd100;

  // register indexes on the config port
  localparam logic REG_MID_OFFSET = 1'b0;

  // kinds of command in the run
  localparam logic [1:0] KIND_SET   = 2'd0;
  localparam logic [1:0] KIND_LOWER = 2'd1;
  localparam logic [1:0] KIND_RAISE = 2'd2;

  localparam logic [2:0] SEG_LOWER = 3'd1;
  localparam logic [2:0] SEG_RAISE = 3'd5;
  localparam logic [2:0] SEG_MID   = 3'd6;

  // [board][channel]
  localparam logic [9:0] POS_ON [2][NumChannels] = '{
    '{10'd385, 10'd375, 10'd385, 10'd375, 10'd382, 10'd375, 10'd354,
      10'd367, 10'd375, 10'd385, 10'd375, 10'd368, 10'd371, 10'd375},
    '{10'd382, 10'd395, 10'd378, 10'd315, 10'd375, 10'd340, 10'd345,
      10'd380, 10'd385, 10'd365, 10'd290, 10'd365, 10'd315, 10'd365}};
  localparam logic [9:0] POS_OFF [2][NumChannels] = '{
    '{10'd200, 10'd200, 10'd550, 10'd480, 10'd200, 10'd520, 10'd200,
      10'd200, 10'd200, 10'd480, 10'd550, 10'd200, 10'd515, 10'd200},
    '{10'd200, 10'd200, 10'd550, 10'd440, 10'd200, 10'd480, 10'd200,
      10'd200, 10'd200, 10'd550, 10'd450, 10'd200, 10'd430, 10'd200}};

  // digit index: 0 minute units, 1 minute tens, 2 hour units, 3 hour tens.
  // mid_mask holds four bits per digit: lower seg 1, raise seg 5, set middle.
  typedef struct packed {
    logic [NumDigits-1:0][3:0] now;
    logic [4*NumDigits-1:0]    mid_mask;
  } ssc_job_t;

  typedef struct packed {
    logic valid;
    logic full;
  } ssc_q_stat_t;

  // bit s set when segment s is lit
  function automatic logic [6:0] seg_lit(input logic [3:0] digit);
    logic [6:0] lit;
    case (digit)
      4'd0:    lit = 7'b0111111;
      4'd1:    lit = 7'b0000110;
      4'd2:    lit = 7'b1011011;
      4'd3:    lit = 7'b1001111;
      4'd4:    lit = 7'b1100110;
      4'd5:    lit = 7'b1101101;
      4'd6:    lit = 7'b1111101;
      4'd7:    lit = 7'b0000111;
      4'd8:    lit = 7'b1111111;
      4'd9:    lit = 7'b1101111;
      default: lit = 7'b0000000;
    endcase
    return lit;
  endfunction

endpackage

>>> rtl/ssc_chan_if.sv
// Handshake channels of the sequencer: time items in, servo commands out.
// No dependencies.
interface ssc_in_if;
  logic       valid;
  logic       ready;
  logic [4:0] hour_of_day;
  logic [5:0] minute_of_hour;

  modport source (output valid, hour_of_day, minute_of_hour, input ready);
  modport sink   (input valid, hour_of_day, minute_of_hour, output ready);
endinterface

interface ssc_out_if;
  logic        valid;
  logic        ready;
  logic        board_select;
  logic [3:0]  servo_channel;
  logic [11:0] pulse_position;
  logic        last_command;

  modport source (output valid, board_select, servo_channel, pulse_position,
                  last_command, input ready);
  modport sink   (input valid, board_select, servo_channel, pulse_position,
                  last_command, output ready);
endinterface

>>> rtl/servo_segment_clock_sequencer.sv
// A run's first servo command passes the job queue, the back end's job registers and
// the output stage. One command per cycle while the receiver is ready, 28 to 36 per
// run, runs back to back; items that leave the minute units digit unchanged produce
// nothing. The 2-entry job queue sets how far item intake runs ahead of the back end.
// Reset (rst_n low, synchronous): displayed digits to zero, mid_offset to 100,
// queue and output stage empty; no clearing pass.
`include "assert_macros.svh"

module servo_segment_clock_sequencer #(
  parameter int unsigned POSITION_WIDTH = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  ssc_in_if.sink      in_chan,
  ssc_out_if.source   out_chan,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [ssc_pkg::OffsetW-1:0] mid_offset_r;
  logic                        cfg_wr;
  logic                        q_push, q_pop, back_busy;
  ssc_pkg::ssc_job_t           front_job, q_head;
  ssc_pkg::ssc_q_stat_t        q_stat;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                  (cfg_paddr[2] == ssc_pkg::REG_MID_OFFSET);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_offset_r <= ssc_pkg::MID_OFFSET_RST;
    end else if (cfg_wr) begin
      mid_offset_r <= cfg_pwdata[ssc_pkg::OffsetW-1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == ssc_pkg::REG_MID_OFFSET) begin
      cfg_prdata = 32'(mid_offset_r);
    end
  end

  ssc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .q_full  (q_stat.full),
    .push    (q_push),
    .job     (front_job)
  );

  ssc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (front_job),
    .pop      (q_pop),
    .head     (q_head),
    .stat     (q_stat)
  );

  ssc_back #(
    .POSITION_WIDTH (POSITION_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .mid_offset (mid_offset_r),
    .q_head     (q_head),
    .q_valid    (q_stat.valid),
    .q_pop      (q_pop),
    .busy       (back_busy),
    .out_chan   (out_chan)
  );

  // a job never lands on a full queue
  `ASSERT_CLK(a_q_no_overflow, !(q_push && q_stat.full), "job pushed into full queue")
  // an idle sequencer picks up a waiting job at once
  `ASSERT_NEXT(a_back_picks_up, !back_busy && q_stat.valid, back_busy, "waiting job not taken")
  // a new command only comes from a running job
  `ASSERT_CLK(a_out_from_job, !$rose(out_chan.valid) || $past(back_busy), "command without job")

endmodule

>>> rtl/ssc_front.sv
// Front end: takes time items, splits them into digits, compares with the
// digits on display and builds a job. Depends on ssc_pkg and ssc_chan_if.
module ssc_front (
  input  logic             clk,
  input  logic             rst_n,
  ssc_in_if.sink           in_chan,
  input  logic             q_full,
  output logic             push,
  output ssc_pkg::ssc_job_t job
);

  logic [1:0] shown_hour_tens_r,    shown_hour_tens_nxt;
  logic [3:0] shown_hour_units_r,   shown_hour_units_nxt;
  logic [2:0] shown_minute_tens_r,  shown_minute_tens_nxt;
  logic [3:0] shown_minute_units_r, shown_minute_units_nxt;

  logic [2:0] hour_tens, minute_tens;
  logic [3:0] hour_units, minute_units;
  logic [ssc_pkg::NumDigits-1:0][3:0] prev;
  logic [6:0] lit_now, lit_prev;
  logic       mid_change;
  logic       accept;

  // x / 10 as (x * 205) >> 11, exact for x below 64
  function automatic logic [2:0] tens_of(input logic [5:0] x);
    logic [13:0] prod;
    prod = 14'(x) * 14'd205;
    return prod[13:11];
  endfunction

  function automatic logic [3:0] units_of(input logic [5:0] x, input logic [2:0] t);
    logic [5:0] tx10;
    tx10 = {t, 3'b000} + {2'b00, t, 1'b0};
    return 4'(x - tx10);
  endfunction

  assign in_chan.ready = !q_full;
  assign accept = in_chan.valid && in_chan.ready;

  always_comb begin
    hour_tens    = tens_of({1'b0, in_chan.hour_of_day});
    hour_units   = units_of({1'b0, in_chan.hour_of_day}, hour_tens);
    minute_tens  = tens_of(in_chan.minute_of_hour);
    minute_units = units_of(in_chan.minute_of_hour, minute_tens);

    job.now[0] = minute_units;
    job.now[1] = {1'b0, minute_tens};
    job.now[2] = hour_units;
    job.now[3] = {1'b0, hour_tens};
    prev[0] = shown_minute_units_r;
    prev[1] = {1'b0, shown_minute_tens_r};
    prev[2] = shown_hour_units_r;
    prev[3] = {2'b00, shown_hour_tens_r};

    job.mid_mask = '0;
    for (int k = 0; k < ssc_pkg::NumDigits; k++) begin
      lit_now    = ssc_pkg::seg_lit(job.now[k]);
      lit_prev   = ssc_pkg::seg_lit(prev[k]);
      mid_change = lit_now[ssc_pkg::SEG_MID] != lit_prev[ssc_pkg::SEG_MID];
      job.mid_mask[4*k]   = mid_change && lit_prev[ssc_pkg::SEG_LOWER];
      // the raise move follows the old middle segment, not segment 5
      job.mid_mask[4*k+1] = mid_change && lit_prev[ssc_pkg::SEG_MID];
      job.mid_mask[4*k+2] = 1'b1;
    end

    push = accept && (minute_units != shown_minute_units_r);

    shown_hour_tens_nxt    = shown_hour_tens_r;
    shown_hour_units_nxt   = shown_hour_units_r;
    shown_minute_tens_nxt  = shown_minute_tens_r;
    shown_minute_units_nxt = shown_minute_units_r;
    if (push) begin
      shown_hour_tens_nxt    = hour_tens[1:0];
      shown_hour_units_nxt   = hour_units;
      shown_minute_tens_nxt  = minute_tens;
      shown_minute_units_nxt = minute_units;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shown_hour_tens_r    <= '0;
      shown_hour_units_r   <= '0;
      shown_minute_tens_r  <= '0;
      shown_minute_units_r <= '0;
    end else begin
      shown_hour_tens_r    <= shown_hour_tens_nxt;
      shown_hour_units_r   <= shown_hour_units_nxt;
      shown_minute_tens_r  <= shown_minute_tens_nxt;
      shown_minute_units_r <= shown_minute_units_nxt;
    end
  end

endmodule

>>> rtl/ssc_queue.sv
// Two-entry job queue between front and back end; head is always entry 0.
// Depends on ssc_pkg.
module ssc_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  ssc_pkg::ssc_job_t    push_job,
  input  logic                 pop,
  output ssc_pkg::ssc_job_t    head,
  output ssc_pkg::ssc_q_stat_t stat
);

  ssc_pkg::ssc_job_t ent_r [2];
  ssc_pkg::ssc_job_t ent_nxt [2];
  logic [1:0] count_r, count_nxt;
  logic [1:0] wr_pos;

  assign head       = ent_r[0];
  assign stat.valid = count_r != 2'd0;
  assign stat.full  = count_r == 2'd2;

  always_comb begin
    ent_nxt[0] = ent_r[0];
    ent_nxt[1] = ent_r[1];
    if (pop) begin
      ent_nxt[0] = ent_r[1];
    end
    wr_pos = count_r - {1'b0, pop};
    if (push) begin
      ent_nxt[wr_pos[0]] = push_job;
    end
    count_nxt = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    ent_r[0] <= ent_nxt[0];
    ent_r[1] <= ent_nxt[1];
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

endmodule

>>> rtl/ssc_back.sv
// Back end: steps through a job's command slots, one servo command a cycle
// bar stalls, into a registered output stage. Uses ssc_pkg and ssc_chan_if.
module ssc_back #(
  parameter int unsigned POSITION_WIDTH = 12
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [ssc_pkg::OffsetW-1:0]   mid_offset,
  input  ssc_pkg::ssc_job_t             q_head,
  input  logic                          q_valid,
  output logic                          q_pop,
  output logic                          busy,
  ssc_out_if.source                     out_chan
);

  localparam logic [16:0] PosMax = 17'((32'd1 << POSITION_WIDTH) - 32'd1);

  logic [ssc_pkg::NumDigits-1:0][3:0] now_r, now_nxt;
  logic [4*ssc_pkg::NumDigits-1:0]    mid_mask_r, mid_mask_nxt;
  logic [4:0]                         cnt_r, cnt_nxt;
  logic                               busy_r, busy_nxt;

  logic                      out_valid_r;
  logic                      board_r;
  logic [3:0]                ch_r;
  logic [POSITION_WIDTH-1:0] pos_r;
  logic                      last_r;

  logic        mid_pending, advance, last, finishing;
  logic [3:0]  low_idx;
  logic [1:0]  d;
  logic [2:0]  seg;
  logic [1:0]  kind;
  logic        board;
  logic [3:0]  ch;
  logic [9:0]  pos_on, pos_off;
  logic [6:0]  lit;
  logic [ssc_pkg::RawW-1:0] raw;
  logic [16:0] raw_ext, clamped, pos_ext;

  always_comb begin
    mid_pending = |mid_mask_r;
    low_idx = '0;
    for (int i = 4 * ssc_pkg::NumDigits - 1; i >= 0; i--) begin
      if (mid_mask_r[i]) begin
        low_idx = 4'(i);
      end
    end

    if (mid_pending) begin
      d = low_idx[3:2];
      case (low_idx[1:0])
        2'd0: begin
          seg  = ssc_pkg::SEG_LOWER;
          kind = ssc_pkg::KIND_LOWER;
        end
        2'd1: begin
          seg  = ssc_pkg::SEG_RAISE;
          kind = ssc_pkg::KIND_RAISE;
        end
        default: begin
          seg  = ssc_pkg::SEG_MID;
          kind = ssc_pkg::KIND_SET;
        end
      endcase
    end else begin
      // normal phase: segment by segment, hour tens first
      d    = 2'd3 - cnt_r[1:0];
      seg  = cnt_r[4:2];
      kind = ssc_pkg::KIND_SET;
    end

    board   = ~d[1];
    ch      = {1'b0, seg} + (d[0] ? 4'd7 : 4'd0);
    pos_on  = ssc_pkg::POS_ON[board][ch];
    pos_off = ssc_pkg::POS_OFF[board][ch];
    lit     = ssc_pkg::seg_lit(now_r[d]);

    case (kind)
      ssc_pkg::KIND_LOWER:
        raw = ({3'b000, pos_on} > {1'b0, mid_offset}) ?
              ({3'b000, pos_on} - {1'b0, mid_offset}) : '0;
      ssc_pkg::KIND_RAISE:
        raw = {3'b000, pos_on} + {1'b0, mid_offset};
      default:
        raw = {3'b000, lit[seg] ? pos_on : pos_off};
    endcase
    raw_ext = 17'(raw);
    clamped = (raw_ext > PosMax) ? PosMax : raw_ext;

    last      = !mid_pending && (cnt_r == 5'(ssc_pkg::NormalSlots - 1));
    advance   = busy_r && (!out_valid_r || out_chan.ready);
    finishing = advance && last;
    q_pop     = q_valid && (!busy_r || finishing);

    busy_nxt     = q_pop ? 1'b1 : (finishing ? 1'b0 : busy_r);
    now_nxt      = q_pop ? q_head.now : now_r;
    mid_mask_nxt = mid_mask_r;
    cnt_nxt      = cnt_r;
    if (q_pop) begin
      mid_mask_nxt = q_head.mid_mask;
      cnt_nxt      = '0;
    end else if (advance && mid_pending) begin
      mid_mask_nxt = mid_mask_r & (mid_mask_r - 1'b1);
    end else if (advance) begin
      cnt_nxt = cnt_r + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    now_r <= now_nxt;
    if (advance) begin
      board_r <= board;
      ch_r    <= ch;
      pos_r   <= clamped[POSITION_WIDTH-1:0];
      last_r  <= last;
    end
    if (!rst_n) begin
      busy_r      <= 1'b0;
      mid_mask_r  <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r     <= busy_nxt;
      mid_mask_r <= mid_mask_nxt;
      cnt_r      <= cnt_nxt;
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign pos_ext                 = 17'(pos_r);
  assign busy                    = busy_r;
  assign out_chan.valid          = out_valid_r;
  assign out_chan.board_select   = board_r;
  assign out_chan.servo_channel  = ch_r;
  assign out_chan.pulse_position = pos_ext[ssc_pkg::PosFieldW-1:0];
  assign out_chan.last_command   = last_r;

endmodule

>>> dv/tb_servo_segment_clock_sequencer.sv
// Self-checking bench for servo_segment_clock_sequencer: time items in, servo commands out.
// Predicts every servo command from its own digit and segment tables.
// Depends on rtl/ssc_pkg.sv, rtl/ssc_chan_if.sv and the block itself.
`timescale 1ns / 100ps

module tb_servo_segment_clock_sequencer;

  localparam int unsigned POS_WIDTH   = 12;
  localparam int unsigned POS_CEIL    = (1 << POS_WIDTH) - 1;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned SETTLE_CYC  = 10;

  // on / off servo counts, [board][channel]
  localparam int unsigned SERVO_ON [2][14] = '{
    '{385, 375, 385, 375, 382, 375, 354, 367, 375, 385, 375, 368, 371, 375},
    '{382, 395, 378, 315, 375, 340, 345, 380, 385, 365, 290, 365, 315, 365}};
  localparam int unsigned SERVO_OFF [2][14] = '{
    '{200, 200, 550, 480, 200, 520, 200, 200, 200, 480, 550, 200, 515, 200},
    '{200, 200, 550, 440, 200, 480, 200, 200, 200, 550, 450, 200, 430, 200}};
  // [digit][segment], 1 = lit
  localparam bit SEG_LIT [10][7] = '{
    '{1, 1, 1, 1, 1, 1, 0}, '{0, 1, 1, 0, 0, 0, 0}, '{1, 1, 0, 1, 1, 0, 1},
    '{1, 1, 1, 1, 0, 0, 1}, '{0, 1, 1, 0, 0, 1, 1}, '{1, 0, 1, 1, 0, 1, 1},
    '{1, 0, 1, 1, 1, 1, 1}, '{1, 1, 1, 0, 0, 0, 0}, '{1, 1, 1, 1, 1, 1, 1},
    '{1, 1, 1, 1, 0, 1, 1}};

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
  } clock_time_t;

  typedef struct packed {
    logic        board;
    logic [3:0]  channel;
    logic [11:0] position;
    logic        last;
  } servo_cmd_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  ssc_in_if  in_chan ();
  ssc_out_if out_chan ();

  servo_segment_clock_sequencer #(.POSITION_WIDTH(POS_WIDTH)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .out_chan   (out_chan),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // predictor state: digits on display and the offset register
  logic [1:0]  shown_hr_tens  = '0;
  logic [3:0]  shown_hr_units = '0;
  logic [2:0]  shown_min_tens = '0;
  logic [3:0]  shown_min_units = '0;
  logic [11:0] offset_setting = ssc_pkg::MID_OFFSET_RST;

  clock_time_t pending_times [$];
  servo_cmd_t  expected_cmds [$];

  clock_time_t tx_now = '0;
  bit          tx_busy = 1'b0;
  int unsigned tx_wait = 0;
  bit          tx_gaps = 1'b0;
  int unsigned rx_wait = 0;
  bit          rx_stalls = 1'b0;
  bit          rx_hold = 1'b0;
  bit          rx_hold_req = 1'b0;
  logic        in_taken = 1'b0;
  logic        out_taken = 1'b0;

  int unsigned mismatches = 0;
  int unsigned items_accepted = 0;
  int unsigned quiet_items = 0;
  int unsigned runs_predicted = 0;
  int unsigned cmds_checked = 0;

  initial begin : clock_and_reset
    clk   = 1'b0;
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  initial begin : clock_gen
    #2;
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  function automatic int unsigned draw_idle();
    return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 16);
  endfunction

  task automatic queue_cmd(input int unsigned brd, input int unsigned ch,
                           input int unsigned value);
    servo_cmd_t cmd;
    cmd.board    = brd[0];
    cmd.channel  = ch[3:0];
    cmd.position = (value > POS_CEIL) ? 12'(POS_CEIL) : 12'(value);
    cmd.last     = 1'b0;
    expected_cmds.push_back(cmd);
  endtask

  task automatic queue_segment(input int unsigned brd, input int unsigned base,
                               input int unsigned digit, input int unsigned seg);
    int unsigned ch;
    ch = base + seg;
    queue_cmd(brd, ch, SEG_LIT[digit][seg] ? SERVO_ON[brd][ch] : SERVO_OFF[brd][ch]);
  endtask

  // Digit index: 0 minute units, 1 minute tens, 2 hour units, 3 hour tens.
  task automatic predict_run(input logic [4:0] hour, input logic [5:0] minute);
    int unsigned now_d [4];
    int unsigned prev_d [4];
    int unsigned brd;
    int unsigned base;
    int unsigned on_cnt;
    servo_cmd_t  tail;
    now_d[0]  = minute % 10;
    now_d[1]  = minute / 10;
    now_d[2]  = hour % 10;
    now_d[3]  = hour / 10;
    prev_d[0] = shown_min_units % 10;
    prev_d[1] = shown_min_tens % 10;
    prev_d[2] = shown_hr_units % 10;
    prev_d[3] = shown_hr_tens % 10;
    if (now_d[0] == prev_d[0]) begin
      quiet_items++;
      return;
    end
    // middle segments first, neighbors pushed aside where the middle flips
    for (int d = 0; d < 4; d++) begin
      brd  = (d < 2) ? 1 : 0;
      base = (d % 2) * 7;
      if (SEG_LIT[now_d[d]][6] != SEG_LIT[prev_d[d]][6]) begin
        if (SEG_LIT[prev_d[d]][1]) begin
          on_cnt = SERVO_ON[brd][base + 1];
          queue_cmd(brd, base + 1, (on_cnt > offset_setting) ? on_cnt - offset_setting : 0);
        end
        // gated on the old middle segment, not on segment 5 itself
        if (SEG_LIT[prev_d[d]][6])
          queue_cmd(brd, base + 5, SERVO_ON[brd][base + 5] + offset_setting);
      end
      queue_segment(brd, base, now_d[d], 6);
    end
    for (int s = 0; s < 6; s++) begin
      for (int d = 3; d >= 0; d--) begin
        queue_segment((d < 2) ? 1 : 0, (d % 2) * 7, now_d[d], s);
      end
    end
    tail      = expected_cmds.pop_back();
    tail.last = 1'b1;
    expected_cmds.push_back(tail);
    shown_min_units = 4'(now_d[0]);
    shown_min_tens  = 3'(now_d[1]);
    shown_hr_units  = 4'(now_d[2]);
    shown_hr_tens   = 2'(now_d[3]);
    runs_predicted++;
  endtask

  task automatic check_command();
    servo_cmd_t want;
    if (expected_cmds.size() == 0) begin
      report_mismatch("command with nothing expected, channel", out_chan.servo_channel, 0);
      return;
    end
    want = expected_cmds.pop_front();
    cmds_checked++;
    if (out_chan.board_select !== want.board)
      report_mismatch("board_select", out_chan.board_select, want.board);
    if (out_chan.servo_channel !== want.channel)
      report_mismatch("servo_channel", out_chan.servo_channel, want.channel);
    if (out_chan.pulse_position !== want.position)
      report_mismatch("pulse_position", out_chan.pulse_position, want.position);
    if (out_chan.last_command !== want.last)
      report_mismatch("last_command", out_chan.last_command, want.last);
  endtask

  // handshakes are seen here, at the rising edge
  always @(posedge clk) begin
    in_taken  <= rst_n && in_chan.valid && in_chan.ready;
    out_taken <= rst_n && out_chan.valid && out_chan.ready;
    if (rst_n && in_chan.valid && in_chan.ready) begin
      items_accepted++;
      predict_run(in_chan.hour_of_day, in_chan.minute_of_hour);
    end
    if (rst_n && out_chan.valid && out_chan.ready)
      check_command();
  end

  // time item driver
  always @(negedge clk) begin
    if (!rst_n) begin
      tx_busy = 1'b0;
      in_chan.valid <= 1'b0;
    end else begin
      if (tx_busy && in_taken) begin
        tx_busy = 1'b0;
        tx_wait = tx_gaps ? draw_idle() : 0;
      end
      if (!tx_busy) begin
        if (tx_wait > 0) begin
          tx_wait = tx_wait - 1;
        end else if (pending_times.size() > 0) begin
          tx_now  = pending_times.pop_front();
          tx_busy = 1'b1;
        end
      end
      in_chan.valid          <= tx_busy;
      in_chan.hour_of_day    <= tx_now.hour;
      in_chan.minute_of_hour <= tx_now.minute;
    end
  end

  // command receiver
  always @(negedge clk) begin
    if (!rst_n) begin
      rx_wait = 0;
      out_chan.ready <= 1'b0;
    end else begin
      if (out_taken)
        rx_wait = rx_stalls ? draw_idle() : 0;
      if (rx_hold) begin
        out_chan.ready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait = rx_wait - 1;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  initial begin : rx_long_hold
    wait (rx_hold_req);
    @(posedge clk);
    rx_hold = 1'b1;
    repeat (LONG_HOLD) @(posedge clk);
    rx_hold = 1'b0;
  end

  task automatic apb_access(input bit is_write, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= is_write;
    cfg_paddr   <= {ssc_pkg::REG_MID_OFFSET, 2'b00};
    cfg_pwdata  <= wdata;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    rdata = cfg_prdata;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic check_offset_reg();
    logic [31:0] rd;
    apb_access(1'b0, '0, rd);
    if (rd !== {20'd0, offset_setting})
      report_mismatch("mid_offset readback", rd, offset_setting);
  endtask

  // idle = nothing queued, nothing on the wire, nothing outstanding, then settle
  task automatic wait_idle();
    while (pending_times.size() > 0 || tx_busy || expected_cmds.size() > 0)
      @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  function automatic clock_time_t random_time();
    clock_time_t t;
    t.hour   = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(24, 31))
                                           : 5'($urandom_range(0, 23));
    t.minute = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(60, 63))
                                           : 6'($urandom_range(0, 59));
    return t;
  endfunction

  // Mostly a ticking clock from a random start; some jumps and repeated minutes.
  task automatic run_phase(input logic [11:0] offset_val, input int unsigned n_items,
                           input bit gaps, input bit stalls, input bit squeeze);
    clock_time_t t;
    logic [31:0] rd;
    int unsigned pick;
    apb_access(1'b1, {20'd0, offset_val}, rd);
    offset_setting = offset_val;
    check_offset_reg();
    tx_gaps   = gaps;
    rx_stalls = stalls;
    if (squeeze)
      rx_hold_req = 1'b1;
    t = random_time();
    repeat (n_items) begin
      pick = $urandom_range(0, 15);
      if (pick == 0) begin
        t = random_time();
      end else if (pick != 1) begin
        if (t.minute >= 59) begin
          t.minute = '0;
          t.hour   = (t.hour >= 23) ? 5'd0 : t.hour + 5'd1;
        end else begin
          t.minute = t.minute + 6'd1;
        end
      end
      pending_times.push_back(t);
    end
    wait_idle();
  endtask

  initial begin : stimulus
    clock_time_t directed [$];
    in_chan.valid          = 1'b0;
    in_chan.hour_of_day    = '0;
    in_chan.minute_of_hour = '0;
    out_chan.ready         = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    wait (rst_n === 1'b1);

    check_offset_reg();
    // zero minute right after reset is silent; later ones walk all digits,
    // middle flips both ways, out of range hours and minutes, repeats
    directed = '{'{5'd0, 6'd0},   '{5'd0, 6'd10},  '{5'd0, 6'd1},   '{5'd12, 6'd2},
                 '{5'd13, 6'd3},  '{5'd13, 6'd13}, '{5'd23, 6'd59}, '{5'd31, 6'd63},
                 '{5'd24, 6'd60}, '{5'd8, 6'd8},   '{5'd19, 6'd17}, '{5'd20, 6'd46},
                 '{5'd21, 6'd55}, '{5'd22, 6'd29}, '{5'd9, 6'd34},  '{5'd10, 6'd0},
                 '{5'd11, 6'd41}, '{5'd30, 6'd62}, '{5'd14, 6'd58}, '{5'd15, 6'd7},
                 '{5'd16, 6'd24}, '{5'd18, 6'd39}, '{5'd7, 6'd6},   '{5'd6, 6'd5}};
    foreach (directed[i])
      pending_times.push_back(directed[i]);
    wait_idle();

    run_phase(12'd0, 25, 1'b1, 1'b1, 1'b0);
    // receiver blocked while the sender streams without gaps
    run_phase(12'hFFF, 16, 1'b0, 1'b0, 1'b1);
    run_phase(12'($urandom_range(0, 4095)), 20, 1'b1, 1'b0, 1'b0);
    run_phase(12'($urandom_range(0, 400)), 20, 1'b0, 1'b1, 1'b0);
    run_phase(ssc_pkg::MID_OFFSET_RST, 15, 1'b1, 1'b1, 1'b0);

    $display("Covered %0d time items: %0d runs, %0d left the display unchanged.",
             items_accepted, runs_predicted, quiet_items);
    $display("Checked %0d servo commands over offsets 0, 4095, 100 and random values.",
             cmds_checked);
    if (mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("timeout: block stopped making progress");
    $display("== FAIL ==");
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/ssc_pkg.sv
rtl/ssc_chan_if.sv
rtl/ssc_front.sv
rtl/ssc_queue.sv
rtl/ssc_back.sv
rtl/servo_segment_clock_sequencer.sv
dv/tb_servo_segment_clock_sequencer.sv
